@@ hw/rtl/dda_pkg.sv @@
// Shared constants, types and operation codes of the line rasteriser.
`default_nettype none
package dda_pkg;

	localparam int unsigned DdaCoordBits = 10;
	localparam int unsigned DdaFracBits  = 16;

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} dda_op_t;

endpackage
`default_nettype wire

@@ hw/rtl/dda_cmd_if.sv @@
// Command channel: line start with endpoints, or tick.
`default_nettype none
interface dda_cmd_if
	import dda_pkg::*;
#(
	parameter int unsigned COORD_BITS = DdaCoordBits
);
	logic                  valid;
	logic                  ready;
	dda_op_t               op;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;

	modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dda_pt_if.sv @@
// Point channel: one plotted pixel per beat.
`default_nettype none
interface dda_pt_if
	import dda_pkg::*;
#(
	parameter int unsigned COORD_BITS = DdaCoordBits
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	logic                  last_point;

	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dda_line_rasterizer_unit.sv @@
// DDA line generator with a shared serial divider for the per-step increments.
//
// The cmd channel takes start beats (two endpoints) and tick beats; the pt
// channel returns plotted points, the last one of each line flagged.
// A start beat places the start point in the output register in the next
// cycle, then one restoring divider works out the x and the y increment in
// turn, one quotient bit a cycle; the cmd channel is held off until both
// increments are done. A zero-length line needs no division and gives
// only its start point, flagged last.
// A tick beat while a line is being drawn adds the increments and yields the
// rounded point in the next cycle; ticks may follow one another every cycle
// while points are taken. A tick while idle is consumed and gives no point.
// The output register lets a new beat be taken in the cycle in which the
// waiting point leaves; while the receiver stalls with a point pending, the
// cmd channel is held off. Reset empties the output register and leaves the
// block idle with no line in progress.
`default_nettype none
module dda_line_rasterizer_unit
	import dda_pkg::*;
#(
	parameter int unsigned COORD_BITS = DdaCoordBits,
	parameter int unsigned FRAC_BITS  = DdaFracBits
) (
	input  wire         clk,
	input  wire         arst_n,
	dda_cmd_if.sink     cmd,
	dda_pt_if.source    pt
);
	localparam int unsigned AccBits = COORD_BITS + FRAC_BITS + 1;
	localparam int unsigned IncBits = FRAC_BITS + 2;
	localparam int unsigned CntBits = $clog2(FRAC_BITS + 1);

	typedef enum logic [1:0] {
		ST_READY = 2'b01,
		ST_DIV   = 2'b10
	} state_t;

	state_t                state_q;
	logic                  active_q;
	logic [AccBits-1:0]    x_acc_q;
	logic [AccBits-1:0]    y_acc_q;
	logic [IncBits-1:0]    x_inc_q;
	logic [IncBits-1:0]    y_inc_q;
	logic [COORD_BITS-1:0] steps_left_q;
	logic [COORD_BITS-1:0] steps_q;
	logic [COORD_BITS-1:0] ady_q;
	logic                  x_neg_q;
	logic                  y_neg_q;
	logic                  div_y_q;
	logic [COORD_BITS:0]   rem_q;
	logic [FRAC_BITS:0]    quo_q;
	logic [CntBits-1:0]    cnt_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_x_q;
	logic [COORD_BITS-1:0] out_y_q;
	logic                  out_last_q;

	logic                  accept;
	logic                  is_start;
	logic                  x_neg;
	logic                  y_neg;
	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic [COORD_BITS-1:0] steps;
	logic [AccBits-1:0]    x_next;
	logic [AccBits-1:0]    y_next;
	logic [AccBits-1:0]    x_round;
	logic [AccBits-1:0]    y_round;
	logic [COORD_BITS-1:0] steps_dec;
	logic                  div_ge;
	logic [COORD_BITS:0]   div_rem;
	logic [FRAC_BITS:0]    quo_full;
	logic [IncBits-1:0]    inc_mag;
	logic [IncBits-1:0]    inc_val;

	assign cmd.ready = (state_q == ST_READY) && (!out_valid_q || pt.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign is_start  = (cmd.op == OP_START);

	assign x_neg = cmd.end_x < cmd.start_x;
	assign y_neg = cmd.end_y < cmd.start_y;
	assign adx   = x_neg ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
	assign ady   = y_neg ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
	assign steps = (adx > ady) ? adx : ady;

	assign x_next  = x_acc_q + {{(AccBits - IncBits){x_inc_q[IncBits-1]}}, x_inc_q};
	assign y_next  = y_acc_q + {{(AccBits - IncBits){y_inc_q[IncBits-1]}}, y_inc_q};
	assign x_round = x_next + (AccBits'(1) << (FRAC_BITS - 1));
	assign y_round = y_next + (AccBits'(1) << (FRAC_BITS - 1));
	assign steps_dec = steps_left_q - COORD_BITS'(1);

	// One restoring division step: compare, subtract, shift in one quotient bit.
	assign div_ge   = rem_q >= {1'b0, steps_q};
	assign div_rem  = div_ge ? rem_q - {1'b0, steps_q} : rem_q;
	assign quo_full = {quo_q[FRAC_BITS-1:0], div_ge};
	assign inc_mag  = {1'b0, quo_full};

	always_comb begin
		if (div_y_q) begin
			inc_val = y_neg_q ? IncBits'(0) - inc_mag : inc_mag;
		end else begin
			inc_val = x_neg_q ? IncBits'(0) - inc_mag : inc_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_READY;
			active_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			steps_left_q <= '0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
			x_inc_q      <= '0;
			y_inc_q      <= '0;
			cnt_q        <= '0;
			div_y_q      <= 1'b0;
		end else begin
			if (accept && (is_start || active_q)) begin
				out_valid_q <= 1'b1;
			end else if (pt.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_READY: begin
					if (accept && is_start) begin
						x_acc_q      <= AccBits'({cmd.start_x, {FRAC_BITS{1'b0}}});
						y_acc_q      <= AccBits'({cmd.start_y, {FRAC_BITS{1'b0}}});
						x_inc_q      <= '0;
						y_inc_q      <= '0;
						steps_left_q <= steps;
						active_q     <= (steps != '0);
						cnt_q        <= CntBits'(FRAC_BITS);
						div_y_q      <= 1'b0;
						if (steps != '0) begin
							state_q <= ST_DIV;
						end
					end else if (accept && active_q) begin
						x_acc_q      <= x_next;
						y_acc_q      <= y_next;
						steps_left_q <= steps_dec;
						active_q     <= (steps_dec != '0);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						cnt_q <= CntBits'(FRAC_BITS);
						if (div_y_q) begin
							y_inc_q <= inc_val;
							state_q <= ST_READY;
						end else begin
							x_inc_q <= inc_val;
							div_y_q <= 1'b1;
						end
					end else begin
						cnt_q <= cnt_q - CntBits'(1);
					end
				end
				default: begin
					state_q <= ST_READY;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_start) begin
			steps_q <= steps;
			ady_q   <= ady;
			x_neg_q <= x_neg;
			y_neg_q <= y_neg;
			rem_q   <= {1'b0, adx};
			quo_q   <= '0;
			out_x_q    <= cmd.start_x;
			out_y_q    <= cmd.start_y;
			out_last_q <= (steps == '0);
		end else if (accept && active_q) begin
			out_x_q    <= x_round[FRAC_BITS +: COORD_BITS];
			out_y_q    <= y_round[FRAC_BITS +: COORD_BITS];
			out_last_q <= (steps_dec == '0);
		end else if (state_q == ST_DIV) begin
			if (cnt_q == '0) begin
				rem_q <= {1'b0, ady_q};
				quo_q <= '0;
			end else begin
				rem_q <= {div_rem[COORD_BITS-1:0], 1'b0};
				quo_q <= quo_full;
			end
		end
	end

	assign pt.valid      = out_valid_q;
	assign pt.point_x    = out_x_q;
	assign pt.point_y    = out_y_q;
	assign pt.last_point = out_last_q;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the DDA line rasteriser: directed and random lines.
`default_nettype none
module tb_top
	import dda_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned FRAC_POS    = DdaFracBits;
	localparam int unsigned POS_BITS    = DdaCoordBits + DdaFracBits + 1;
	localparam int unsigned STEP_BITS   = DdaFracBits + 2;

	typedef logic [DdaCoordBits-1:0] coord_t;
	typedef logic [POS_BITS-1:0]     pos_t;
	typedef logic [STEP_BITS-1:0]    step_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dda_cmd_if cmd_ch ();
	dda_pt_if  pt_ch ();

	dda_line_rasterizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pt     (pt_ch)
	);

	always #5 clk = ~clk;

	// Predicted state of the line generator.
	pos_t   x_pos;
	pos_t   y_pos;
	step_t  x_step;
	step_t  y_step;
	coord_t steps_left;
	bit     drawing;

	point_t expected_points[$];
	int unsigned points_sent;
	int unsigned mismatches;
	int unsigned cycle_count;
	bit steady;

	function automatic step_t line_increment(input coord_t from, input coord_t to,
			input coord_t steps);
		logic [DdaCoordBits+DdaFracBits-1:0] scaled;
		step_t q;
		scaled = {(to >= from) ? coord_t'(to - from) : coord_t'(from - to),
			{DdaFracBits{1'b0}}};
		q = step_t'(scaled / steps);
		if (to < from)
			q = -q;
		return q;
	endfunction

	function automatic coord_t pixel_of(input pos_t pos);
		pos_t r;
		r = pos + (pos_t'(1) << (FRAC_POS - 1));
		return r[FRAC_POS +: DdaCoordBits];
	endfunction

	function automatic bit predict_point(input dda_op_t op, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey, output point_t p);
		coord_t adx;
		coord_t ady;
		coord_t steps;
		p = '0;
		if (op == OP_START) begin
			adx = (ex >= sx) ? coord_t'(ex - sx) : coord_t'(sx - ex);
			ady = (ey >= sy) ? coord_t'(ey - sy) : coord_t'(sy - ey);
			steps = (adx > ady) ? adx : ady;
			x_pos = {1'b0, sx, {DdaFracBits{1'b0}}};
			y_pos = {1'b0, sy, {DdaFracBits{1'b0}}};
			if (steps == 0) begin
				x_step = '0;
				y_step = '0;
				steps_left = '0;
				drawing = 1'b0;
			end else begin
				x_step = line_increment(sx, ex, steps);
				y_step = line_increment(sy, ey, steps);
				steps_left = steps;
				drawing = 1'b1;
			end
			p = '{x: sx, y: sy, last: !drawing};
			return 1'b1;
		end
		if (!drawing)
			return 1'b0;
		x_pos = x_pos + {{(POS_BITS-STEP_BITS){x_step[STEP_BITS-1]}}, x_step};
		y_pos = y_pos + {{(POS_BITS-STEP_BITS){y_step[STEP_BITS-1]}}, y_step};
		steps_left = steps_left - 1'b1;
		if (steps_left == 0)
			drawing = 1'b0;
		p = '{x: pixel_of(x_pos), y: pixel_of(y_pos), last: !drawing};
		return 1'b1;
	endfunction

	task automatic send_cmd(input dda_op_t op, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		point_t p;
		bit has_point;
		while (!steady && $urandom_range(99) < 21) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.op      <= op;
		cmd_ch.start_x <= sx;
		cmd_ch.start_y <= sy;
		cmd_ch.end_x   <= ex;
		cmd_ch.end_y   <= ey;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		has_point = predict_point(op, sx, sy, ex, ey, p);
		if (has_point) begin
			expected_points.push_back(p);
			points_sent++;
		end
	endtask

	task automatic send_tick();
		send_cmd(OP_TICK, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom));
	endtask

	// A negative cut runs the whole line; extra ticks then land while idle.
	task automatic draw_line(input coord_t sx, input coord_t sy, input coord_t ex,
			input coord_t ey, input int cut, input int extra);
		int ticks;
		send_cmd(OP_START, sx, sy, ex, ey);
		ticks = (cut >= 0 && cut < int'(steps_left)) ? cut : int'(steps_left);
		if (ticks == int'(steps_left))
			ticks += extra;
		repeat (ticks)
			send_tick();
	endtask

	function automatic coord_t near_coord(input coord_t base, input int reach);
		int offset;
		int c;
		offset = int'($urandom_range(2 * reach)) - reach;
		c = int'(base) + offset;
		if (c < 0 || c > (1 << DdaCoordBits) - 1)
			c = int'(base) - offset;
		return coord_t'(c);
	endfunction

	task automatic random_line();
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		int reach;
		int pick;
		sx = coord_t'($urandom);
		sy = coord_t'($urandom);
		pick = $urandom_range(99);
		reach = (pick < 80) ? 15 : 100;
		if (pick >= 95) begin
			ex = coord_t'($urandom);
			ey = coord_t'($urandom);
		end else begin
			ex = near_coord(sx, reach);
			ey = near_coord(sy, reach);
		end
		if ($urandom_range(99) < 20)
			draw_line(sx, sy, ex, ey, $urandom_range(reach), 0);
		else if (pick >= 95)
			draw_line(sx, sy, ex, ey, $urandom_range(300), $urandom_range(2));
		else
			draw_line(sx, sy, ex, ey, -1, $urandom_range(2));
	endtask

	task automatic test_idle_tick();
		send_tick();
		send_tick();
	endtask

	task automatic test_directed();
		draw_line(10'd0, 10'd0, 10'd0, 10'd0, -1, 1);
		draw_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, -1, 0);
		draw_line(10'd5, 10'd5, 10'd6, 10'd9, -1, 0);
		draw_line(10'd10, 10'd10, 10'd7, 10'd8, -1, 1);
		draw_line(10'd1023, 10'd0, 10'd1020, 10'd3, -1, 0);
		draw_line(10'd0, 10'd1023, 10'd2, 10'd1023, -1, 0);
		draw_line(10'd100, 10'd200, 10'd110, 10'd190, 2, 0);
		draw_line(10'd512, 10'd512, 10'd509, 10'd514, -1, 0);
	endtask

	task automatic test_random_lines(input int unsigned target);
		while (points_sent < target) begin
			if ($urandom_range(99) < 10) begin
				if ($urandom_range(1))
					send_tick();
				else
					send_cmd(OP_START, coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom));
			end else begin
				random_line();
			end
		end
	endtask

	task automatic test_back_to_back(input int unsigned target);
		steady = 1'b1;
		while (points_sent < target)
			random_line();
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		pt_ch.ready <= steady || ($urandom_range(99) >= 21);
	end

	always @(posedge clk) begin
		point_t want;
		if (arst_n && pt_ch.valid && pt_ch.ready) begin
			if (expected_points.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected point x=%0d y=%0d last=%0b", pt_ch.point_x,
						pt_ch.point_y, pt_ch.last_point);
				mismatches++;
			end else begin
				want = expected_points.pop_front();
				if (pt_ch.point_x !== want.x || pt_ch.point_y !== want.y ||
						pt_ch.last_point !== want.last) begin
					if (mismatches < 10)
						$display({"point mismatch: expected x=%0d y=%0d last=%0b, ",
							"got x=%0d y=%0d last=%0b"},
							want.x, want.y, want.last, pt_ch.point_x, pt_ch.point_y,
							pt_ch.last_point);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		cmd_ch.valid   = 1'b0;
		cmd_ch.op      = OP_START;
		cmd_ch.start_x = '0;
		cmd_ch.start_y = '0;
		cmd_ch.end_x   = '0;
		cmd_ch.end_y   = '0;
		pt_ch.ready    = 1'b0;
		steady         = 1'b0;
		points_sent    = 0;
		mismatches     = 0;
		cycle_count    = 0;
		x_pos          = '0;
		y_pos          = '0;
		x_step         = '0;
		y_step         = '0;
		steps_left     = '0;
		drawing        = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_tick();
		test_directed();
		test_random_lines(1200);
		test_back_to_back(1600);
		cmd_ch.valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		mismatches += expected_points.size();
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/dda_pkg.sv
hw/rtl/dda_cmd_if.sv
hw/rtl/dda_pt_if.sv
hw/rtl/dda_line_rasterizer_unit.sv
tb/tb_top.sv
